/* rtl/abm4_pkg.sv */
`timescale 1ns / 1ps
// abm4_pkg: types, constants, saturation and the micro-op program of the drag/fall integrator
// no dependencies; used by every other file of the block but abm4_if

package abm4_pkg;

  // widths that follow from the 32 bit fields
  localparam int PROD_W = 65;  // signed 33 x 32 product
  localparam int ACC_W  = 41;  // weighted sums of up to 160 * 2^31
  localparam int PC_W   = 6;

  // register reset values
  localparam logic signed [31:0] RST_INIT_V = 32'sd196608;
  localparam logic signed [31:0] RST_INIT_Y = 32'sd9830400;
  localparam logic        [30:0] RST_DRAG   = 31'd65536;
  localparam logic        [30:0] RST_STEP_H = 31'd6554;
  localparam logic signed [31:0] RST_T0     = 32'sd0;
  localparam logic        [15:0] RST_LIMIT  = 16'd150;

  localparam logic [4:0] DIVISOR_6  = 5'd6;
  localparam logic [4:0] DIVISOR_24 = 5'd24;

  // program entry points
  localparam logic [PC_W-1:0] PC_RK  = 6'd0;
  localparam logic [PC_W-1:0] PC_AB  = 6'd21;
  localparam logic [PC_W-1:0] PC_RST = 6'd42;

  typedef enum logic [2:0] {
    CFG_INIT_V = 3'd0,
    CFG_INIT_Y = 3'd1,
    CFG_DRAG   = 3'd2,
    CFG_STEP_H = 3'd3,
    CFG_T0     = 3'd4,
    CFG_LIMIT  = 3'd5
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_DERIV, OP_ADV, OP_ADVH, OP_MACF, OP_MAC, OP_DIV, OP_END
  } op_e;

  typedef enum logic [4:0] {
    SRC_V, SRC_K1, SRC_K2, SRC_K3, SRC_K4, SRC_V2, SRC_V3, SRC_V4,
    SRC_AH0, SRC_AH1, SRC_AH2, SRC_AH3, SRC_VH0, SRC_VH1, SRC_VH2, SRC_VH3,
    SRC_VP, SRC_FP, SRC_Q, SRC_VN
  } src_e;

  typedef enum logic [3:0] {
    DST_K1, DST_K2, DST_K3, DST_K4, DST_V2, DST_V3, DST_V4,
    DST_VP, DST_FP, DST_VN, DST_YN, DST_AN
  } dst_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ISSUE, ST_POST, ST_DIV, ST_PUB
  } ctrl_state_e;

  typedef struct packed {
    op_e               op;
    logic signed [7:0] coef;
    src_e              src;
    dst_e              dst;
    logic              div24;
  } uop_t;

  typedef struct packed {
    logic signed [31:0] init_velocity;
    logic signed [31:0] init_height;
    logic        [30:0] drag_ratio;
    logic        [30:0] time_step;
    logic signed [31:0] start_time;
    logic        [15:0] step_limit;
  } cfg_t;

  typedef struct packed {
    logic mul_en;
    logic post_en;
    logic div_start;
    logic load_init;
    logic commit_step;
    logic commit_rst;
    logic pub;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic lt_limit;
    logic lt_three;
    logic div_done;
  } sts_t;

  typedef struct packed {
    logic        [15:0] step_index;
    logic signed [31:0] sim_time;
    logic signed [31:0] velocity_out;
    logic signed [31:0] height_out;
    logic signed [31:0] peak_height;
    logic        [15:0] peak_step;
    logic signed [31:0] peak_time;
    logic               near_sea_level;
    logic               finished;
  } out_t;

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) r = 32'sh7fffffff;
    else if (x < -66'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

  function automatic uop_t mk(input op_e op, input logic signed [7:0] coef,
                              input src_e src, input dst_e dst, input logic div24);
    uop_t u;
    u.op = op; u.coef = coef; u.src = src; u.dst = dst; u.div24 = div24;
    return u;
  endfunction

  // runge-kutta step, adams step, restart
  function automatic uop_t uop_rom(input logic [PC_W-1:0] pc);
    uop_t u;
    u = mk(OP_END, 8'sd0, SRC_V, DST_K1, 1'b0);
    case (pc)
      6'd0:  u = mk(OP_DERIV, 8'sd0,   SRC_V,   DST_K1, 1'b0);
      6'd1:  u = mk(OP_ADVH,  8'sd0,   SRC_K1,  DST_V2, 1'b0);
      6'd2:  u = mk(OP_DERIV, 8'sd0,   SRC_V2,  DST_K2, 1'b0);
      6'd3:  u = mk(OP_ADVH,  8'sd0,   SRC_K2,  DST_V3, 1'b0);
      6'd4:  u = mk(OP_DERIV, 8'sd0,   SRC_V3,  DST_K3, 1'b0);
      6'd5:  u = mk(OP_ADV,   8'sd0,   SRC_K3,  DST_V4, 1'b0);
      6'd6:  u = mk(OP_DERIV, 8'sd0,   SRC_V4,  DST_K4, 1'b0);
      6'd7:  u = mk(OP_MACF,  8'sd1,   SRC_K1,  DST_K1, 1'b0);
      6'd8:  u = mk(OP_MAC,   8'sd2,   SRC_K2,  DST_K1, 1'b0);
      6'd9:  u = mk(OP_MAC,   8'sd2,   SRC_K3,  DST_K1, 1'b0);
      6'd10: u = mk(OP_MAC,   8'sd1,   SRC_K4,  DST_K1, 1'b0);
      6'd11: u = mk(OP_DIV,   8'sd0,   SRC_V,   DST_K1, 1'b0);
      6'd12: u = mk(OP_ADV,   8'sd0,   SRC_Q,   DST_VN, 1'b0);
      6'd13: u = mk(OP_MACF,  8'sd1,   SRC_V,   DST_K1, 1'b0);
      6'd14: u = mk(OP_MAC,   8'sd2,   SRC_V2,  DST_K1, 1'b0);
      6'd15: u = mk(OP_MAC,   8'sd2,   SRC_V3,  DST_K1, 1'b0);
      6'd16: u = mk(OP_MAC,   8'sd1,   SRC_V4,  DST_K1, 1'b0);
      6'd17: u = mk(OP_DIV,   8'sd0,   SRC_V,   DST_K1, 1'b0);
      6'd18: u = mk(OP_ADV,   8'sd0,   SRC_Q,   DST_YN, 1'b0);
      6'd19: u = mk(OP_DERIV, 8'sd0,   SRC_VN,  DST_AN, 1'b0);
      6'd20: u = mk(OP_END,   8'sd0,   SRC_V,   DST_K1, 1'b0);
      6'd21: u = mk(OP_MACF,  8'sd55,  SRC_AH0, DST_K1, 1'b0);
      6'd22: u = mk(OP_MAC,   -8'sd59, SRC_AH1, DST_K1, 1'b0);
      6'd23: u = mk(OP_MAC,   8'sd37,  SRC_AH2, DST_K1, 1'b0);
      6'd24: u = mk(OP_MAC,   -8'sd9,  SRC_AH3, DST_K1, 1'b0);
      6'd25: u = mk(OP_DIV,   8'sd0,   SRC_V,   DST_K1, 1'b1);
      6'd26: u = mk(OP_ADV,   8'sd0,   SRC_Q,   DST_VP, 1'b0);
      6'd27: u = mk(OP_DERIV, 8'sd0,   SRC_VP,  DST_FP, 1'b0);
      6'd28: u = mk(OP_MACF,  8'sd1,   SRC_AH2, DST_K1, 1'b0);
      6'd29: u = mk(OP_MAC,   -8'sd5,  SRC_AH1, DST_K1, 1'b0);
      6'd30: u = mk(OP_MAC,   8'sd19,  SRC_AH0, DST_K1, 1'b0);
      6'd31: u = mk(OP_MAC,   8'sd9,   SRC_FP,  DST_K1, 1'b0);
      6'd32: u = mk(OP_DIV,   8'sd0,   SRC_V,   DST_K1, 1'b1);
      6'd33: u = mk(OP_ADV,   8'sd0,   SRC_Q,   DST_VN, 1'b0);
      6'd34: u = mk(OP_MACF,  8'sd1,   SRC_VH2, DST_K1, 1'b0);
      6'd35: u = mk(OP_MAC,   -8'sd5,  SRC_VH1, DST_K1, 1'b0);
      6'd36: u = mk(OP_MAC,   8'sd19,  SRC_VH0, DST_K1, 1'b0);
      6'd37: u = mk(OP_MAC,   8'sd9,   SRC_VP,  DST_K1, 1'b0);
      6'd38: u = mk(OP_DIV,   8'sd0,   SRC_V,   DST_K1, 1'b1);
      6'd39: u = mk(OP_ADV,   8'sd0,   SRC_Q,   DST_YN, 1'b0);
      6'd40: u = mk(OP_DERIV, 8'sd0,   SRC_VN,  DST_AN, 1'b0);
      6'd41: u = mk(OP_END,   8'sd0,   SRC_V,   DST_K1, 1'b0);
      6'd42: u = mk(OP_DERIV, 8'sd0,   SRC_V,   DST_AN, 1'b0);
      default: u = mk(OP_END, 8'sd0,   SRC_V,   DST_K1, 1'b0);
    endcase
    return u;
  endfunction

endpackage

/* rtl/abm4_if.sv */
`timescale 1ns / 1ps
// abm4_in_if / abm4_out_if: valid/ready channels of the integrator
// payload types follow the field widths; no package dependency

interface abm4_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface abm4_out_if;
  logic               valid;
  logic               ready;
  logic        [15:0] step_index;
  logic signed [31:0] sim_time;
  logic signed [31:0] velocity_out;
  logic signed [31:0] height_out;
  logic signed [31:0] peak_height;
  logic        [15:0] peak_step;
  logic signed [31:0] peak_time;
  logic               near_sea_level;
  logic               finished;
  modport source (output valid, output step_index, output sim_time, output velocity_out,
                  output height_out, output peak_height, output peak_step, output peak_time,
                  output near_sea_level, output finished, input ready);
  modport sink (input valid, input step_index, input sim_time, input velocity_out,
                input height_out, input peak_height, input peak_step, input peak_time,
                input near_sea_level, input finished, output ready);
endinterface

/* rtl/abm4_div.sv */
`timescale 1ns / 1ps
// abm4_div: rounded divide by 6 or 24, shift then two reciprocal steps
// depends on abm4_pkg

module abm4_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [abm4_pkg::ACC_W-1:0]  dividend_i,
  input  logic                               div24_i,
  output logic                               done_o,
  output logic signed [31:0]                 quot_o
);
  localparam int AW = abm4_pkg::ACC_W;
  // (2^19 + 1) / 3: exact floor(x / 3) for any x below 2^19
  localparam logic [17:0] RECIP_3 = 18'd174763;

  logic [4:0]         dvs;
  logic [AW-1:0]      mag, num, lim;
  logic               ovf;
  logic [32:0]        n3;
  logic [32:0]        n_q;
  logic               neg_q, ovf_q;
  logic               hi_q, lo_q, done_q;
  logic [14:0]        qhi_q;
  logic [1:0]         r_q;
  logic [18:0]        x_sel;
  logic [36:0]        rcp_prod;
  logic [16:0]        q3;
  logic [1:0]         r3;
  logic [31:0]        q_full;
  logic signed [31:0] res;
  logic signed [31:0] quot_q;

  assign dvs = div24_i ? abm4_pkg::DIVISOR_24 : abm4_pkg::DIVISOR_6;
  assign mag = dividend_i[AW-1] ? AW'(-dividend_i) : AW'(dividend_i);
  // ties away from zero: add half the divisor to the magnitude
  assign num = mag + AW'(dvs >> 1);
  // a quotient of 2^31 or more saturates for either sign
  assign lim = AW'(dvs) << 31;
  assign ovf = num >= lim;
  // divide by 2 or 8 first, a divide by 3 is left
  assign n3  = div24_i ? num[35:3] : num[33:1];

  // one divide-by-3 digit step of 17 bits, upper digit first
  assign x_sel    = hi_q ? {3'b000, n_q[32:17]} : {r_q, n_q[16:0]};
  assign rcp_prod = 37'(x_sel) * 37'(RECIP_3);
  assign q3       = rcp_prod[35:19];
  assign r3       = 2'(x_sel - 19'(q3) * 19'd3);
  assign q_full   = {qhi_q, q3};

  always_comb begin
    if (ovf_q)      res = neg_q ? 32'sh80000000 : 32'sh7fffffff;
    else if (neg_q) res = -$signed(q_full);
    else            res = $signed(q_full);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q   <= 1'b0;
      lo_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      hi_q   <= start_i;
      lo_q   <= hi_q;
      done_q <= lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= n3;
      neg_q <= dividend_i[AW-1];
      ovf_q <= ovf;
    end
    if (hi_q) begin
      qhi_q <= q3[14:0];
      r_q   <= r3;
    end
    if (lo_q) quot_q <= res;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
endmodule

/* rtl/abm4_dp.sv */
`timescale 1ns / 1ps
// abm4_dp: state, history, shared multiplier, post-adders and output register
// depends on abm4_pkg and abm4_div

module abm4_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  abm4_pkg::cfg_t   cfg_i,
  input  abm4_pkg::cmd_t   cmd_i,
  output abm4_pkg::sts_t   sts_o,
  output abm4_pkg::out_t   out_o
);
  localparam int PW = abm4_pkg::PROD_W;
  localparam int AW = abm4_pkg::ACC_W;

  localparam logic signed [PW-1:0] HALF_F  = PW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0] HALF_F1 = PW'(1) <<< FRAC_BITS;
  localparam logic signed [PW:0]   TEN_F   = (PW+1)'(10) <<< FRAC_BITS;
  localparam logic signed [32:0]   ONE_F   = 33'(1) <<< FRAC_BITS;
  // derivative of the reset velocity under the reset drag ratio
  localparam logic signed [PW:0] AH0_RST_SUM = -TEN_F
      - (((PW+1)'(abm4_pkg::RST_DRAG) * (PW+1)'(abm4_pkg::RST_INIT_V)
          + (PW+1)'(HALF_F)) >>> FRAC_BITS);
  localparam logic signed [31:0] AH0_RST = abm4_pkg::sat32(AH0_RST_SUM);

  abm4_pkg::uop_t uop;

  logic signed [31:0] v_q, y_q, t_q;
  logic        [15:0] step_q;
  logic signed [31:0] pk_y_q, pk_t_q;
  logic        [15:0] pk_step_q;
  logic signed [31:0] ah_q [4];
  logic signed [31:0] vh_q [4];
  logic signed [31:0] k1_q, k2_q, k3_q, k4_q, v2_q, v3_q, v4_q, vp_q, fp_q, vn_q, yn_q, an_q;
  logic signed [PW-1:0] prod_q, prod_d;
  logic signed [AW-1:0] acc_q;
  abm4_pkg::out_t out_q;

  logic signed [32:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [PW-1:0] rnd_f, rnd_f1, rnd_sel;
  logic signed [31:0] base, deriv_val, adv_val, post_val, t_next, quot;
  logic        [15:0] step_next;
  logic               div_done;

  assign uop = cmd_i.uop;

  // operand b of the shared multiplier
  always_comb begin
    case (uop.src)
      abm4_pkg::SRC_V:   mul_b = v_q;
      abm4_pkg::SRC_K1:  mul_b = k1_q;
      abm4_pkg::SRC_K2:  mul_b = k2_q;
      abm4_pkg::SRC_K3:  mul_b = k3_q;
      abm4_pkg::SRC_K4:  mul_b = k4_q;
      abm4_pkg::SRC_V2:  mul_b = v2_q;
      abm4_pkg::SRC_V3:  mul_b = v3_q;
      abm4_pkg::SRC_V4:  mul_b = v4_q;
      abm4_pkg::SRC_AH0: mul_b = ah_q[0];
      abm4_pkg::SRC_AH1: mul_b = ah_q[1];
      abm4_pkg::SRC_AH2: mul_b = ah_q[2];
      abm4_pkg::SRC_AH3: mul_b = ah_q[3];
      abm4_pkg::SRC_VH0: mul_b = vh_q[0];
      abm4_pkg::SRC_VH1: mul_b = vh_q[1];
      abm4_pkg::SRC_VH2: mul_b = vh_q[2];
      abm4_pkg::SRC_VH3: mul_b = vh_q[3];
      abm4_pkg::SRC_VP:  mul_b = vp_q;
      abm4_pkg::SRC_FP:  mul_b = fp_q;
      abm4_pkg::SRC_Q:   mul_b = quot;
      abm4_pkg::SRC_VN:  mul_b = vn_q;
      default:           mul_b = v_q;
    endcase
  end

  always_comb begin
    case (uop.op)
      abm4_pkg::OP_DERIV:                  mul_a = $signed({2'b00, cfg_i.drag_ratio});
      abm4_pkg::OP_ADV, abm4_pkg::OP_ADVH: mul_a = $signed({2'b00, cfg_i.time_step});
      abm4_pkg::OP_MACF, abm4_pkg::OP_MAC: mul_a = 33'(uop.coef);
      default:                             mul_a = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // rounding to nearest, ties up
  assign rnd_f   = (prod_q + HALF_F) >>> FRAC_BITS;
  assign rnd_f1  = (prod_q + HALF_F1) >>> (FRAC_BITS + 1);
  assign rnd_sel = (uop.op == abm4_pkg::OP_ADVH) ? rnd_f1 : rnd_f;
  assign base    = (uop.dst == abm4_pkg::DST_YN) ? y_q : v_q;

  assign deriv_val = abm4_pkg::sat32(-TEN_F - (PW+1)'(rnd_f));
  assign adv_val   = abm4_pkg::sat32((PW+1)'(base) + (PW+1)'(rnd_sel));
  assign post_val  = (uop.op == abm4_pkg::OP_DERIV) ? deriv_val : adv_val;

  assign step_next = step_q + 16'd1;
  assign t_next    = abm4_pkg::sat32((PW+1)'(t_q) + (PW+1)'(cfg_i.time_step));

  abm4_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (acc_q),
    .div24_i    (uop.div24),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // scratch values of the current step
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= prod_d;
    if (cmd_i.post_en) begin
      case (uop.op)
        abm4_pkg::OP_MACF: acc_q <= prod_q[AW-1:0];
        abm4_pkg::OP_MAC:  acc_q <= acc_q + prod_q[AW-1:0];
        abm4_pkg::OP_DERIV, abm4_pkg::OP_ADV, abm4_pkg::OP_ADVH: begin
          case (uop.dst)
            abm4_pkg::DST_K1: k1_q <= post_val;
            abm4_pkg::DST_K2: k2_q <= post_val;
            abm4_pkg::DST_K3: k3_q <= post_val;
            abm4_pkg::DST_K4: k4_q <= post_val;
            abm4_pkg::DST_V2: v2_q <= post_val;
            abm4_pkg::DST_V3: v3_q <= post_val;
            abm4_pkg::DST_V4: v4_q <= post_val;
            abm4_pkg::DST_VP: vp_q <= post_val;
            abm4_pkg::DST_FP: fp_q <= post_val;
            abm4_pkg::DST_VN: vn_q <= post_val;
            abm4_pkg::DST_YN: yn_q <= post_val;
            abm4_pkg::DST_AN: an_q <= post_val;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  // architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q       <= abm4_pkg::RST_INIT_V;
      y_q       <= abm4_pkg::RST_INIT_Y;
      t_q       <= abm4_pkg::RST_T0;
      step_q    <= '0;
      pk_y_q    <= abm4_pkg::RST_INIT_Y;
      pk_t_q    <= abm4_pkg::RST_T0;
      pk_step_q <= '0;
      for (int i = 0; i < 4; i++) begin
        ah_q[i] <= '0;
        vh_q[i] <= '0;
      end
      ah_q[0] <= AH0_RST;
      vh_q[0] <= abm4_pkg::RST_INIT_V;
    end else if (cmd_i.load_init) begin
      v_q       <= cfg_i.init_velocity;
      y_q       <= cfg_i.init_height;
      t_q       <= cfg_i.start_time;
      step_q    <= '0;
      pk_y_q    <= cfg_i.init_height;
      pk_t_q    <= cfg_i.start_time;
      pk_step_q <= '0;
      for (int i = 0; i < 4; i++) begin
        ah_q[i] <= '0;
        vh_q[i] <= '0;
      end
    end else if (cmd_i.commit_rst) begin
      ah_q[0] <= an_q;
      vh_q[0] <= v_q;
    end else if (cmd_i.commit_step) begin
      v_q    <= vn_q;
      y_q    <= yn_q;
      t_q    <= t_next;
      step_q <= step_next;
      for (int i = 3; i > 0; i--) begin
        ah_q[i] <= ah_q[i-1];
        vh_q[i] <= vh_q[i-1];
      end
      ah_q[0] <= an_q;
      vh_q[0] <= vn_q;
      // strictly greater only
      if (yn_q > pk_y_q) begin
        pk_y_q    <= yn_q;
        pk_step_q <= step_next;
        pk_t_q    <= t_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pub) begin
      out_q.step_index     <= step_q;
      out_q.sim_time       <= t_q;
      out_q.velocity_out   <= v_q;
      out_q.height_out     <= y_q;
      out_q.peak_height    <= pk_y_q;
      out_q.peak_step      <= pk_step_q;
      out_q.peak_time      <= pk_t_q;
      out_q.near_sea_level <= (33'(y_q) < ONE_F) && (33'(y_q) > -ONE_F);
      out_q.finished       <= step_q >= cfg_i.step_limit;
    end
  end

  assign sts_o.lt_limit = step_q < cfg_i.step_limit;
  assign sts_o.lt_three = step_q < 16'd3;
  assign sts_o.div_done = div_done;
  assign out_o          = out_q;
endmodule

/* rtl/abm4_ctrl.sv */
`timescale 1ns / 1ps
// abm4_ctrl: sequencer over the micro-op program, handshakes of both channels
// depends on abm4_pkg

module abm4_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           restart_i,
  output logic           in_ready_o,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  input  abm4_pkg::sts_t sts_i,
  output abm4_pkg::cmd_t cmd_o
);
  abm4_pkg::ctrl_state_e state_q, state_d;
  logic [abm4_pkg::PC_W-1:0] pc_q, pc_d;
  logic mode_rst_q, mode_rst_d;
  logic out_valid_q, out_valid_d;
  logic slot_free;
  abm4_pkg::uop_t uop;

  assign uop       = abm4_pkg::uop_rom(pc_q);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    pc_d       = pc_q;
    mode_rst_d = mode_rst_q;
    unique case (state_q)
      abm4_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (restart_i) begin
            state_d    = abm4_pkg::ST_ISSUE;
            pc_d       = abm4_pkg::PC_RST;
            mode_rst_d = 1'b1;
          end else if (sts_i.lt_limit) begin
            state_d    = abm4_pkg::ST_ISSUE;
            pc_d       = sts_i.lt_three ? abm4_pkg::PC_RK : abm4_pkg::PC_AB;
            mode_rst_d = 1'b0;
          end else begin
            state_d = abm4_pkg::ST_PUB;
          end
        end
      end
      abm4_pkg::ST_ISSUE: begin
        case (uop.op)
          abm4_pkg::OP_DIV: state_d = abm4_pkg::ST_DIV;
          abm4_pkg::OP_END: state_d = abm4_pkg::ST_PUB;
          default:          state_d = abm4_pkg::ST_POST;
        endcase
      end
      abm4_pkg::ST_POST: begin
        state_d = abm4_pkg::ST_ISSUE;
        pc_d    = pc_q + 1'b1;
      end
      abm4_pkg::ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = abm4_pkg::ST_ISSUE;
          pc_d    = pc_q + 1'b1;
        end
      end
      abm4_pkg::ST_PUB: begin
        if (slot_free) state_d = abm4_pkg::ST_IDLE;
      end
      default: state_d = abm4_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    cmd_o.uop   = uop;
    in_ready_o  = 1'b0;
    unique case (state_q)
      abm4_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_init = in_valid_i && restart_i;
      end
      abm4_pkg::ST_ISSUE: begin
        case (uop.op)
          abm4_pkg::OP_DIV: cmd_o.div_start = 1'b1;
          abm4_pkg::OP_END: begin
            cmd_o.commit_rst  = mode_rst_q;
            cmd_o.commit_step = !mode_rst_q;
          end
          default: cmd_o.mul_en = 1'b1;
        endcase
      end
      abm4_pkg::ST_POST: cmd_o.post_en = 1'b1;
      abm4_pkg::ST_DIV:  ;
      abm4_pkg::ST_PUB:  cmd_o.pub = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.pub)        out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= abm4_pkg::ST_IDLE;
      pc_q        <= '0;
      mode_rst_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      mode_rst_q  <= mode_rst_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
endmodule

/* rtl/abm4_drag_fall_integrator.sv */
`timescale 1ns / 1ps
// abm4_drag_fall_integrator: top level, configuration registers, controller and datapath
// depends on abm4_pkg, abm4_if, abm4_ctrl, abm4_dp (and abm4_div below it)
//
//  channel   dir  fields
//  in_if     in   restart
//  out_if    out  step_index sim_time velocity_out height_out peak_height
//                 peak_step peak_time near_sea_level finished
//  cfg       in   cfg_we_i cfg_idx_i cfg_wdata_i (write only)
//
// one request at a time: a restart, a held step (limit reached), a runge-kutta step
// or an adams step; a held step goes straight to publish
// each product is formed on the shared multiplier and then post-added; each rounded
// divide by 6 or 24 runs issue, operand prep, two reciprocal steps of a divide by 3
// the result becomes valid in the same cycle in which the next request can be taken
// async reset gives the state of a restart under the reset register values
// a new request is taken while the previous result waits in the output register;
// it then stalls in publish until that result is taken

module abm4_drag_fall_integrator #(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  abm4_in_if.sink           in_if,
  abm4_out_if.source        out_if,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i
);
  abm4_pkg::cfg_t cfg_q;
  abm4_pkg::cmd_t cmd;
  abm4_pkg::sts_t sts;
  abm4_pkg::out_t res;
  logic           out_valid;

  // config registers; drag, step and limit act at once, initial values at restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.init_velocity <= abm4_pkg::RST_INIT_V;
      cfg_q.init_height   <= abm4_pkg::RST_INIT_Y;
      cfg_q.drag_ratio    <= abm4_pkg::RST_DRAG;
      cfg_q.time_step     <= abm4_pkg::RST_STEP_H;
      cfg_q.start_time    <= abm4_pkg::RST_T0;
      cfg_q.step_limit    <= abm4_pkg::RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        abm4_pkg::CFG_INIT_V: cfg_q.init_velocity <= cfg_wdata_i;
        abm4_pkg::CFG_INIT_Y: cfg_q.init_height   <= cfg_wdata_i;
        abm4_pkg::CFG_DRAG:   cfg_q.drag_ratio    <= cfg_wdata_i[30:0];
        abm4_pkg::CFG_STEP_H: cfg_q.time_step     <= cfg_wdata_i[30:0];
        abm4_pkg::CFG_T0:     cfg_q.start_time    <= cfg_wdata_i;
        abm4_pkg::CFG_LIMIT:  cfg_q.step_limit    <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // sequencer: walks the micro-op program and runs both handshakes
  abm4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .restart_i   (in_if.restart),
    .in_ready_o  (in_if.ready),
    .out_ready_i (out_if.ready),
    .out_valid_o (out_valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // datapath: state, history, multiplier, divider, output register
  abm4_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .out_o  (res)
  );

  assign out_if.valid          = out_valid;
  assign out_if.step_index     = res.step_index;
  assign out_if.sim_time       = res.sim_time;
  assign out_if.velocity_out   = res.velocity_out;
  assign out_if.height_out     = res.height_out;
  assign out_if.peak_height    = res.peak_height;
  assign out_if.peak_step      = res.peak_step;
  assign out_if.peak_time      = res.peak_time;
  assign out_if.near_sea_level = res.near_sea_level;
  assign out_if.finished       = res.finished;

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("request taken while previous one still in work");

  // peak record never below the current height
  a_peak_ge_height: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.peak_height >= out_if.height_out))
    else $error("peak height below current height");

  // peak step never ahead of the step count
  a_peak_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.peak_step <= out_if.step_index))
    else $error("peak step beyond step index");
endmodule
